// ===== design/fat12_cluster_chain_table_unit_macros.svh =====
// Assertion macros shared by the cluster chain table modules.
`ifndef FAT12_CLUSTER_CHAIN_TABLE_UNIT_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_TABLE_UNIT_MACROS_SVH

// Holds at every edge out of reset.
`define FCCT_ASSERT_ALW(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define FCCT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FCCT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fcct_pkg.sv =====
// Types, codes and constants of the cluster chain table.
`default_nettype none

package fcct_pkg;

	localparam int unsigned FCCT_TABLE_DEPTH = 4096;

	// Queue depths between the parts
	localparam int unsigned CMD_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Entry values
	localparam logic [11:0] ENTRY_FIRST_NEXT = 12'h002;
	localparam logic [11:0] ENTRY_MAX_NEXT = 12'hff6;
	localparam logic [11:0] ENTRY_BAD = 12'hff7;
	localparam logic [11:0] ENTRY_END_FIRST = 12'hff8;

	// Configuration port
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;
	localparam logic REG_CLUSTER_LIMIT = 1'b0;
	localparam logic [12:0] LIMIT_RESET = 13'd2880;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_QUERY = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		ST_NEXT = 3'd0,
		ST_BAD = 3'd1,
		ST_END = 3'd2,
		ST_RANGE = 3'd3,
		ST_FREE = 3'd4
	} status_t;

	typedef struct packed {
		logic is_query;
		logic out_of_range;
		logic [10:0] pair_index;
		logic [23:0] packed_bytes;
		logic [11:0] cluster;
	} cmd_t;

	typedef struct packed {
		logic [11:0] next_cluster;
		status_t status;
	} res_t;

	localparam int unsigned CMD_W = $bits(cmd_t);
	localparam int unsigned RES_W = $bits(res_t);

endpackage

`default_nettype wire

// ===== design/fcct_fifo.sv =====
// Small register queue used between the front, the back and the result port.
`default_nettype none
`include "fat12_cluster_chain_table_unit_macros.svh"

module fcct_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] wdata,
	output logic full,
	input wire logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	`FCCT_ASSERT_ALW(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "queue overfilled")
	`FCCT_ASSERT_NXT(a_count_up, clk, arst_n, do_push && !do_pop,
		count_q == $past(count_q) + 1'b1, "queue count missed a push")

endmodule

`default_nettype wire

// ===== design/fcct_front.sv =====
// Front part: decodes and classifies incoming items into back commands.
`default_nettype none

module fcct_front #(
	parameter int unsigned TABLE_DEPTH = fcct_pkg::FCCT_TABLE_DEPTH
) (
	input wire logic push,
	output logic full,
	input wire logic req_type,
	input wire logic [10:0] pair_index,
	input wire logic [23:0] packed_bytes,
	input wire logic [11:0] cluster,
	input wire logic [12:0] cluster_limit,
	input wire logic cmd_full,
	output logic cmd_push,
	output fcct_pkg::cmd_t cmd
);

	localparam int unsigned ROW_DEPTH = (TABLE_DEPTH + 1) / 2;

	logic is_query;
	logic drop;

	assign is_query = (req_type == fcct_pkg::REQ_QUERY);
	// Drop a load whose pair lies wholly past the table
	assign drop = !is_query && ({1'b0, pair_index} >= 12'(ROW_DEPTH));

	assign full = cmd_full;
	assign cmd_push = push & ~cmd_full & ~drop;

	always_comb begin
		cmd.is_query = is_query;
		cmd.out_of_range = (cluster[11:1] == '0)
			|| ({1'b0, cluster} >= cluster_limit)
			|| ({1'b0, cluster} >= 13'(TABLE_DEPTH));
		cmd.pair_index = pair_index;
		cmd.packed_bytes = packed_bytes;
		cmd.cluster = cluster;
	end

endmodule

`default_nettype wire

// ===== design/fcct_back.sv =====
// Back part: table memory, at most one access per command, entry classification.
`default_nettype none
`include "fat12_cluster_chain_table_unit_macros.svh"

module fcct_back #(
	parameter int unsigned TABLE_DEPTH = fcct_pkg::FCCT_TABLE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_empty,
	input wire fcct_pkg::cmd_t cmd,
	output logic cmd_pop,
	input wire logic [fcct_pkg::OUT_CNT_W-1:0] out_count,
	output logic res_push,
	output fcct_pkg::res_t res
);

	localparam int unsigned ROW_DEPTH = (TABLE_DEPTH + 1) / 2;
	localparam int unsigned ROW_AW = $clog2(ROW_DEPTH);
	localparam int unsigned SUM_W = fcct_pkg::OUT_CNT_W + 1;

	// One row holds an entry pair exactly as packed on the bus
	logic [23:0] mem_q [ROW_DEPTH];
	logic valid_s1;
	logic range_s1;
	logic half_s1;
	logic [23:0] row_s1;
	logic room;
	logic [11:0] entry;

	// Hold back commands unless the result queue has room for every query in flight
	assign room = (SUM_W'(out_count) + SUM_W'(valid_s1)) < SUM_W'(fcct_pkg::OUT_DEPTH);
	assign cmd_pop = ~cmd_empty & room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop & cmd.is_query;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && !cmd.is_query) begin
			mem_q[cmd.pair_index[ROW_AW-1:0]] <= cmd.packed_bytes;
		end
		if (cmd_pop && cmd.is_query && !cmd.out_of_range) begin
			row_s1 <= mem_q[cmd.cluster[ROW_AW:1]];
		end
		if (cmd_pop) begin
			range_s1 <= cmd.out_of_range;
			half_s1 <= cmd.cluster[0];
		end
	end

	assign entry = half_s1 ? row_s1[23:12] : row_s1[11:0];
	assign res_push = valid_s1;

	always_comb begin
		res.next_cluster = '0;
		priority if (range_s1) begin
			res.status = fcct_pkg::ST_RANGE;
		end else if (entry >= fcct_pkg::ENTRY_FIRST_NEXT && entry <= fcct_pkg::ENTRY_MAX_NEXT) begin
			res.status = fcct_pkg::ST_NEXT;
			res.next_cluster = entry;
		end else if (entry == fcct_pkg::ENTRY_BAD) begin
			res.status = fcct_pkg::ST_BAD;
		end else if (entry >= fcct_pkg::ENTRY_END_FIRST) begin
			res.status = fcct_pkg::ST_END;
		end else begin
			res.status = fcct_pkg::ST_FREE;
		end
	end

	`FCCT_ASSERT_IMP(a_res_room, clk, arst_n, valid_s1,
		out_count < fcct_pkg::OUT_CNT_W'(fcct_pkg::OUT_DEPTH), "result pushed into a full queue")
	`FCCT_ASSERT_IMP(a_next_zero, clk, arst_n, res_push && res.status != fcct_pkg::ST_NEXT,
		res.next_cluster == '0, "successor not cleared for a non-next status")

endmodule

`default_nettype wire

// ===== design/fat12_cluster_chain_table_unit.sv =====
// FAT12 cluster chain table: packed entry loads and successor queries, the top level.
// The unit takes one item a cycle while the command queue is not full; a load that
// falls wholly past the table is dropped at the front and costs nothing further. Each
// accepted command uses the single table memory port at most once, so the back also
// sustains one item a cycle while the result queue has room. A query's result passes
// the command queue and the back's s1 stage into the result queue; a load gives
// no result. The table holds TABLE_DEPTH 12-bit entries as rows of two, is not cleared
// at reset and must be loaded before it is queried. cluster_limit (byte address 0)
// resets to 2880 and should only be written while the unit has no work outstanding.
`default_nettype none

module fat12_cluster_chain_table_unit #(
	parameter int unsigned TABLE_DEPTH = fcct_pkg::FCCT_TABLE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [fcct_pkg::APB_AW-1:0] paddr,
	input wire logic [fcct_pkg::APB_DW-1:0] pwdata,
	output logic [fcct_pkg::APB_DW-1:0] prdata,
	output logic pready,
	// items in
	input wire logic push,
	output logic full,
	input wire logic req_type,
	input wire logic [10:0] pair_index,
	input wire logic [23:0] packed_bytes,
	input wire logic [11:0] cluster,
	// results out
	output logic empty,
	input wire logic pop,
	output logic [11:0] next_cluster,
	output logic [2:0] status
);

	logic [12:0] limit_q;
	logic cfg_wr;
	logic cmd_push;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	fcct_pkg::cmd_t cmd_in;
	fcct_pkg::cmd_t cmd_head;
	logic [$clog2(fcct_pkg::CMD_DEPTH+1)-1:0] cmd_count;
	logic res_push;
	fcct_pkg::res_t res_in;
	fcct_pkg::res_t res_head;
	logic res_full;
	logic [fcct_pkg::OUT_CNT_W-1:0] res_count;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fcct_pkg::LIMIT_RESET;
		end else if (cfg_wr && paddr[2] == fcct_pkg::REG_CLUSTER_LIMIT) begin
			limit_q <= pwdata[12:0];
		end
	end

	assign prdata = (paddr[2] == fcct_pkg::REG_CLUSTER_LIMIT)
		? {{(fcct_pkg::APB_DW - 13){1'b0}}, limit_q} : '0;

	fcct_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.push(push),
		.full(full),
		.req_type(req_type),
		.pair_index(pair_index),
		.packed_bytes(packed_bytes),
		.cluster(cluster),
		.cluster_limit(limit_q),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd(cmd_in)
	);

	fcct_fifo #(
		.WIDTH(fcct_pkg::CMD_W),
		.DEPTH(fcct_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wdata(cmd_in),
		.full(cmd_full),
		.pop(cmd_pop),
		.rdata(cmd_head),
		.empty(cmd_empty),
		.count(cmd_count)
	);

	fcct_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(cmd_empty),
		.cmd(cmd_head),
		.cmd_pop(cmd_pop),
		.out_count(res_count),
		.res_push(res_push),
		.res(res_in)
	);

	fcct_fifo #(
		.WIDTH(fcct_pkg::RES_W),
		.DEPTH(fcct_pkg::OUT_DEPTH)
	) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.rdata(res_head),
		.empty(empty),
		.count(res_count)
	);

	assign next_cluster = res_head.next_cluster;
	assign status = res_head.status;

	`include "fat12_cluster_chain_table_unit_macros.svh"

	`FCCT_ASSERT_IMP(a_no_lost_result, clk, arst_n, res_push, !res_full,
		"result arrived at a full result queue")
	`FCCT_ASSERT_IMP(a_cmd_order, clk, arst_n, cmd_pop, cmd_count != '0,
		"command taken from an empty queue")

endmodule

`default_nettype wire
